>>> hdl/bbcs_pkg.sv
`default_nettype none

package bbcs_pkg;

   // Storage sizes
   localparam int MAX_BOUNDARIES  = 16;
   localparam int MAX_GRID_POINTS = 256;

   // Field widths
   localparam int IDX_W   = 4;
   localparam int POS_W   = 8;
   localparam int GRID_W  = 9;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_POINTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOUNDARY_COUNT = 2'd1;

   // Item kinds
   localparam logic KIND_RESET   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   // Register reset values
   localparam logic [GRID_W-1:0]  GRID_POINTS_RESET    = 9'd20;
   localparam logic [COUNT_W-1:0] BOUNDARY_COUNT_RESET = 5'd4;

   typedef logic [POS_W-1:0] pos_array_type [MAX_BOUNDARIES];

   typedef struct packed {
      logic ok;
      logic layout_valid;
   } step_status_type;

endpackage

`default_nettype wire

>>> hdl/bbcs_step.sv
`default_nettype none

module bbcs_step (
   input  bbcs_pkg::pos_array_type                 pos,
   input  logic                                    kind,
   input  logic [bbcs_pkg::IDX_W-1:0]              start_boundary,
   input  logic [bbcs_pkg::COUNT_W-1:0]            count,
   input  logic [bbcs_pkg::GRID_W-1:0]             grid,
   output bbcs_pkg::pos_array_type                 pos_next,
   output bbcs_pkg::step_status_type               status
);

   logic [bbcs_pkg::MAX_BOUNDARIES-1:0] free;
   logic                                found;
   logic [bbcs_pkg::IDX_W-1:0]          jsel;
   logic [bbcs_pkg::POS_W-1:0]          base;
   logic                                in_range;
   logic                                order_ok;
   logic [bbcs_pkg::IDX_W-1:0]          top_idx;

   // A point is free when it is on the grid and the right neighbor does not sit on it
   always_comb begin
      for (int j = 0; j < bbcs_pkg::MAX_BOUNDARIES; j++) begin
         logic [bbcs_pkg::GRID_W-1:0] nxt;
         nxt = {1'b0, pos[j]} + bbcs_pkg::GRID_W'(1);
         free[j] = (nxt < grid);
         if (j + 1 < bbcs_pkg::MAX_BOUNDARIES) begin
            if ((bbcs_pkg::COUNT_W'(j + 1) < count) && ({1'b0, pos[j+1]} == nxt)) begin
               free[j] = 1'b0;
            end
         end
      end
   end

   // Highest free boundary at or below the start boundary
   always_comb begin
      in_range = ({1'b0, start_boundary} < count);
      found    = 1'b0;
      jsel     = '0;
      for (int j = 0; j < bbcs_pkg::MAX_BOUNDARIES; j++) begin
         if (free[j] && (bbcs_pkg::IDX_W'(j) <= start_boundary)) begin
            found = 1'b1;
            jsel  = bbcs_pkg::IDX_W'(j);
         end
      end
      found = found && in_range;
      base  = pos[jsel] + bbcs_pkg::POS_W'(1);
   end

   always_comb begin
      for (int m = 0; m < bbcs_pkg::MAX_BOUNDARIES; m++) begin
         logic [bbcs_pkg::IDX_W-1:0] mi;
         mi = bbcs_pkg::IDX_W'(m);
         if (kind == bbcs_pkg::KIND_RESET) begin
            pos_next[m] = bbcs_pkg::POS_W'(m);
         end else if (found && (mi >= jsel) && (mi <= start_boundary)) begin
            // Pack the boundaries from j up to the start boundary against each other
            pos_next[m] = base + bbcs_pkg::POS_W'(mi - jsel);
         end else begin
            pos_next[m] = pos[m];
         end
      end
   end

   always_comb begin
      order_ok = 1'b1;
      for (int i = 0; i + 1 < bbcs_pkg::MAX_BOUNDARIES; i++) begin
         if ((bbcs_pkg::COUNT_W'(i + 1) < count) && !(pos_next[i] < pos_next[i+1])) begin
            order_ok = 1'b0;
         end
      end
      top_idx = bbcs_pkg::IDX_W'(count - bbcs_pkg::COUNT_W'(1));
      status.layout_valid = order_ok && ({1'b0, pos_next[top_idx]} < grid);
      status.ok = (kind == bbcs_pkg::KIND_RESET) || found;
   end

endmodule

`default_nettype wire

>>> hdl/bin_boundary_combination_stepper_unit.sv
`default_nettype none

// Channel   Direction  Payload
// req_      in         tdata[3:0] start_boundary; tuser[0] kind
// rsp_      out        tdata[3:0] boundary_index, [11:4] position; tuser[0] ok,
//                      [1] layout_valid; tlast = last
// csr_      in         index 0 grid_points, 1 boundary_count; data[8:0]
//
// Each transaction is resolved in the cycle it is accepted; the boundary registers
// update at that edge and a snapshot feeds the result side. One item gives K
// results (K up to 16), one per cycle while rsp_ is not stalled, all through the
// single result port. The next transaction is taken in the cycle the
// last result leaves. A stall on rsp_ holds the current result. Reset (synchronous)
// places boundary i at point i and restores the register defaults.

module bin_boundary_combination_stepper_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [3:0] start_boundary, [7:4] zero
   input  wire logic [0:0]  req_tuser,   // [0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [3:0] boundary_index, [11:4] position, [15:12] zero
   output logic [1:0]       rsp_tuser,   // [0] ok, [1] layout_valid
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   logic [bbcs_pkg::GRID_W-1:0]  grid_points_ff;
   logic [bbcs_pkg::COUNT_W-1:0] boundary_count_ff;
   logic [bbcs_pkg::GRID_W-1:0]  grid_eff;
   logic [bbcs_pkg::COUNT_W-1:0] count_eff;

   bbcs_pkg::pos_array_type      pos_ff;
   bbcs_pkg::pos_array_type      pos_in;
   bbcs_pkg::pos_array_type      snap_ff;
   bbcs_pkg::step_status_type    status_in;
   bbcs_pkg::step_status_type    status_ff;

   logic                         busy_ff;
   logic [bbcs_pkg::IDX_W-1:0]   out_idx_ff;
   logic [bbcs_pkg::COUNT_W-1:0] out_count_ff;

   logic req_accept;
   logic rsp_accept;
   logic last_beat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_points_ff    <= bbcs_pkg::GRID_POINTS_RESET;
         boundary_count_ff <= bbcs_pkg::BOUNDARY_COUNT_RESET;
      end else if (csr_valid) begin
         if (csr_index == bbcs_pkg::REG_GRID_POINTS) begin
            grid_points_ff <= csr_data;
         end else if (csr_index == bbcs_pkg::REG_BOUNDARY_COUNT) begin
            boundary_count_ff <= csr_data[bbcs_pkg::COUNT_W-1:0];
         end
      end
   end

   // Clamp the configuration to what the storage holds
   always_comb begin
      if (boundary_count_ff == '0) begin
         count_eff = bbcs_pkg::COUNT_W'(1);
      end else if (boundary_count_ff > bbcs_pkg::COUNT_W'(bbcs_pkg::MAX_BOUNDARIES)) begin
         count_eff = bbcs_pkg::COUNT_W'(bbcs_pkg::MAX_BOUNDARIES);
      end else begin
         count_eff = boundary_count_ff;
      end
      if (grid_points_ff > bbcs_pkg::GRID_W'(bbcs_pkg::MAX_GRID_POINTS)) begin
         grid_eff = bbcs_pkg::GRID_W'(bbcs_pkg::MAX_GRID_POINTS);
      end else begin
         grid_eff = grid_points_ff;
      end
   end

   bbcs_step u_step (
      .pos            (pos_ff),
      .kind           (req_tuser[0]),
      .start_boundary (req_tdata[bbcs_pkg::IDX_W-1:0]),
      .count          (count_eff),
      .grid           (grid_eff),
      .pos_next       (pos_in),
      .status         (status_in)
   );

   assign last_beat  = ({1'b0, out_idx_ff} == (out_count_ff - bbcs_pkg::COUNT_W'(1)));
   assign rsp_accept = busy_ff && rsp_tready;
   assign req_tready = !busy_ff || (rsp_accept && last_beat);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bbcs_pkg::MAX_BOUNDARIES; i++) begin
            pos_ff[i] <= bbcs_pkg::POS_W'(i);
         end
      end else if (req_accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_idx_ff <= '0;
      end else if (req_accept) begin
         busy_ff    <= 1'b1;
         out_idx_ff <= '0;
      end else if (rsp_accept) begin
         if (last_beat) begin
            busy_ff <= 1'b0;
         end else begin
            out_idx_ff <= out_idx_ff + bbcs_pkg::IDX_W'(1);
         end
      end
   end

   // Snapshot of the item's results; no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         snap_ff      <= pos_in;
         status_ff    <= status_in;
         out_count_ff <= count_eff;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {4'd0, snap_ff[out_idx_ff], out_idx_ff};
   assign rsp_tuser  = {status_ff.layout_valid, status_ff.ok};
   assign rsp_tlast  = last_beat;

endmodule

`default_nettype wire
